[rtl/rcbp_pkg.sv]
// ----------------------------------------------------------------------------
// rcbp_pkg
// Shared widths, register codes and helpers for the RC band-pass cascade.
// ----------------------------------------------------------------------------
`default_nettype none

package rcbp_pkg;

  localparam int MAX_SECTIONS = 8;
  localparam int SEC_IDX_W    = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int SECTIONS_W = 4;
  localparam int VAL_W      = 24;            // section values, signed Q4.20
  localparam int MUL_W      = VAL_W + 2;     // serial multiplicand
  localparam int ACC_W      = MUL_W + 2;     // serial adder width
  localparam int PART_W     = ACC_W - 1;     // running partial product
  localparam int CNT_W      = $clog2(COEF_W);
  localparam int OUT_SHIFT  = 5;             // Q4.20 -> Q1.15
  localparam int RND_W      = VAL_W + 1;
  localparam int QUOT_W     = RND_W - OUT_SHIFT;

  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 4;

  localparam logic [COEF_W-1:0]     LP_COEFF_RST = 16'd11816;
  localparam logic [COEF_W-1:0]     HP_COEFF_RST = 16'd63538;
  localparam logic [SECTIONS_W-1:0] SECTIONS_RST = 4'd4;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_LP_COEFF = 2'd0;
  localparam logic [1:0] REG_HP_COEFF = 2'd1;
  localparam logic [1:0] REG_SECTIONS = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;

  // saturate a wide signed sum to the section value range
  function automatic val_t sat_val(input logic signed [ACC_W-1:0] v);
    val_t r;
    if (&v[ACC_W-1:VAL_W-1] || ~|v[ACC_W-1:VAL_W-1]) begin
      r = v[VAL_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/rc_bandpass_cascade.sv]
// Each active section runs LP load, multiply, finish, then HP load, multiply, finish;
// ST_OUT registers the result once the output is free. One request at a time.
// A new request is taken while a finished result still waits in the output register.
// Each coefficient multiply is bit-serial, one coefficient bit per cycle over a 28-bit
// adder through all 16 coefficient bits, two multiplies per section.
// Reset: coefficients and section count return to their defaults, section state clears.
// ----------------------------------------------------------------------------
// rc_bandpass_cascade
// Cascade of first-order RC low-pass / high-pass sections with APB config port.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_bandpass_cascade (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [rcbp_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                                in_restart,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [rcbp_pkg::SAMPLE_W-1:0]     out_filtered,
  output logic                                     out_clipped,
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [rcbp_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [rcbp_pkg::DATA_W-1:0]         pwdata,
  output logic [rcbp_pkg::DATA_W-1:0]              prdata,
  output logic                                     pready
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_LP_LOAD = 3'd1;
  localparam logic [2:0] ST_LP_MUL  = 3'd2;
  localparam logic [2:0] ST_LP_FIN  = 3'd3;
  localparam logic [2:0] ST_HP_LOAD = 3'd4;
  localparam logic [2:0] ST_HP_MUL  = 3'd5;
  localparam logic [2:0] ST_HP_FIN  = 3'd6;
  localparam logic [2:0] ST_OUT     = 3'd7;

  localparam int IDX_W = rcbp_pkg::SEC_IDX_W;

  // configuration registers
  logic [rcbp_pkg::COEF_W-1:0]     lp_coeff_r;
  logic [rcbp_pkg::COEF_W-1:0]     hp_coeff_r;
  logic [rcbp_pkg::SECTIONS_W-1:0] sections_r;

  // section state
  rcbp_pkg::val_t lp_mem_r [rcbp_pkg::MAX_SECTIONS];
  rcbp_pkg::val_t hp_mem_r [rcbp_pkg::MAX_SECTIONS];

  // control
  logic [2:0]                  state_r, state_nxt;
  logic [IDX_W-1:0]            sec_r, sec_nxt;
  logic [IDX_W-1:0]            last_r, last_nxt;
  logic [rcbp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // datapath
  rcbp_pkg::val_t                      x_r, x_nxt;
  rcbp_pkg::val_t                      y_r, y_nxt;
  logic signed [rcbp_pkg::MUL_W-1:0]   d_r, d_nxt;
  logic signed [rcbp_pkg::PART_W-1:0]  p_r, p_nxt;
  logic                                rbit_r, rbit_nxt;
  logic [rcbp_pkg::COEF_W-1:0]         coef_r, coef_nxt;
  logic signed [rcbp_pkg::SAMPLE_W-1:0] filt_r, filt_nxt;
  logic                                clip_r, clip_nxt;

  logic                                in_acc;
  logic                                out_free;
  logic                                cfg_wr;
  logic [1:0]                          reg_idx;
  rcbp_pkg::val_t                      yprev;
  rcbp_pkg::val_t                      zprev;
  logic signed [rcbp_pkg::ACC_W-1:0]   addend;
  logic signed [rcbp_pkg::ACC_W-1:0]   step_sum;
  logic signed [rcbp_pkg::ACC_W-1:0]   lp_sum;
  logic signed [rcbp_pkg::ACC_W-1:0]   hp_sum;
  logic signed [rcbp_pkg::ACC_W-1:0]   rnd_bit;
  logic signed [rcbp_pkg::RND_W-1:0]   out_rnd;
  logic signed [rcbp_pkg::QUOT_W-1:0]  out_q;
  logic [rcbp_pkg::SECTIONS_W:0]       sec_cnt_ext;
  logic                                mem_wr;
  logic                                clr_mem;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_filtered = filt_r;
  assign out_clipped  = clip_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[rcbp_pkg::ADDR_W-1:2];

  assign yprev = lp_mem_r[sec_r];
  assign zprev = hp_mem_r[sec_r];

  // one coefficient bit per cycle, LSB first; partial product shifts right
  assign addend   = coef_r[0] ? rcbp_pkg::ACC_W'(d_r) : '0;
  assign step_sum = rcbp_pkg::ACC_W'(p_r) + addend;
  // last bit shifted out is bit 15 of the full product: half-up rounding
  assign rnd_bit  = rcbp_pkg::ACC_W'($signed({1'b0, rbit_r}));
  assign lp_sum   = rcbp_pkg::ACC_W'(yprev) + rcbp_pkg::ACC_W'(p_r) + rnd_bit;
  assign hp_sum   = rcbp_pkg::ACC_W'(p_r) + rnd_bit;

  assign out_rnd  = rcbp_pkg::RND_W'(x_r)
                  + (rcbp_pkg::RND_W'(1) << (rcbp_pkg::OUT_SHIFT - 1));
  assign out_q    = out_rnd[rcbp_pkg::RND_W-1:rcbp_pkg::OUT_SHIFT];

  assign sec_cnt_ext = {1'b0, sections_r};
  assign mem_wr  = (state_r == ST_HP_FIN);
  assign clr_mem = in_acc && in_restart;

  always_comb begin
    state_nxt     = state_r;
    sec_nxt       = sec_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    d_nxt         = d_r;
    p_nxt         = p_r;
    rbit_nxt      = rbit_r;
    coef_nxt      = coef_r;
    filt_nxt      = filt_r;
    clip_nxt      = clip_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_nxt   = rcbp_pkg::VAL_W'($signed({in_sample, {rcbp_pkg::OUT_SHIFT{1'b0}}}));
          sec_nxt = '0;
          // count of zero runs one section, anything above the maximum runs all
          if (sections_r == '0) begin
            last_nxt = '0;
          end else if (sec_cnt_ext > (rcbp_pkg::SECTIONS_W+1)'(rcbp_pkg::MAX_SECTIONS)) begin
            last_nxt = IDX_W'(rcbp_pkg::MAX_SECTIONS - 1);
          end else begin
            last_nxt = IDX_W'(sections_r - 1'b1);
          end
          state_nxt = ST_LP_LOAD;
        end
      end
      ST_LP_LOAD: begin
        // y = y' + a*(x - y') / 2^16
        d_nxt     = rcbp_pkg::MUL_W'(x_r) - rcbp_pkg::MUL_W'(yprev);
        coef_nxt  = lp_coeff_r;
        p_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = ST_LP_MUL;
      end
      ST_LP_MUL, ST_HP_MUL: begin
        p_nxt    = step_sum[rcbp_pkg::ACC_W-1:1];
        rbit_nxt = step_sum[0];
        coef_nxt = coef_r >> 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == rcbp_pkg::CNT_W'(rcbp_pkg::COEF_W - 1)) begin
          state_nxt = (state_r == ST_LP_MUL) ? ST_LP_FIN : ST_HP_FIN;
        end
      end
      ST_LP_FIN: begin
        y_nxt     = rcbp_pkg::sat_val(lp_sum);
        state_nxt = ST_HP_LOAD;
      end
      ST_HP_LOAD: begin
        // z = b*(z' + y - y') / 2^16
        d_nxt     = rcbp_pkg::MUL_W'(zprev) + rcbp_pkg::MUL_W'(y_r)
                  - rcbp_pkg::MUL_W'(yprev);
        coef_nxt  = hp_coeff_r;
        p_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = ST_HP_MUL;
      end
      ST_HP_FIN: begin
        x_nxt = rcbp_pkg::sat_val(hp_sum);
        if (sec_r == last_r) begin
          state_nxt = ST_OUT;
        end else begin
          sec_nxt   = sec_r + 1'b1;
          state_nxt = ST_LP_LOAD;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          if (&out_q[rcbp_pkg::QUOT_W-1:rcbp_pkg::SAMPLE_W-1]
              || ~|out_q[rcbp_pkg::QUOT_W-1:rcbp_pkg::SAMPLE_W-1]) begin
            filt_nxt = out_q[rcbp_pkg::SAMPLE_W-1:0];
            clip_nxt = 1'b0;
          end else begin
            filt_nxt = out_q[rcbp_pkg::QUOT_W-1]
                     ? {1'b1, {(rcbp_pkg::SAMPLE_W-1){1'b0}}}
                     : {1'b0, {(rcbp_pkg::SAMPLE_W-1){1'b1}}};
            clip_nxt = 1'b1;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sec_r       <= '0;
      last_r      <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sec_r       <= sec_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    d_r    <= d_nxt;
    p_r    <= p_nxt;
    rbit_r <= rbit_nxt;
    coef_r <= coef_nxt;
    filt_r <= filt_nxt;
    clip_r <= clip_nxt;
  end

  // section state: cleared by reset or a restart request, written at section end
  always_ff @(posedge clk) begin
    if (!rst_n || clr_mem) begin
      for (int i = 0; i < rcbp_pkg::MAX_SECTIONS; i++) begin
        lp_mem_r[i] <= '0;
        hp_mem_r[i] <= '0;
      end
    end else if (mem_wr) begin
      lp_mem_r[sec_r] <= y_r;
      hp_mem_r[sec_r] <= x_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_coeff_r <= rcbp_pkg::LP_COEFF_RST;
      hp_coeff_r <= rcbp_pkg::HP_COEFF_RST;
      sections_r <= rcbp_pkg::SECTIONS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rcbp_pkg::REG_LP_COEFF: lp_coeff_r <= pwdata[rcbp_pkg::COEF_W-1:0];
        rcbp_pkg::REG_HP_COEFF: hp_coeff_r <= pwdata[rcbp_pkg::COEF_W-1:0];
        rcbp_pkg::REG_SECTIONS: sections_r <= pwdata[rcbp_pkg::SECTIONS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rcbp_pkg::REG_LP_COEFF: prdata = rcbp_pkg::DATA_W'(lp_coeff_r);
      rcbp_pkg::REG_HP_COEFF: prdata = rcbp_pkg::DATA_W'(hp_coeff_r);
      rcbp_pkg::REG_SECTIONS: prdata = rcbp_pkg::DATA_W'(sections_r);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_sec_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (sec_r <= last_r))
    else $error("section index beyond last active section");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_LP_LOAD))
    else $error("accepted request did not start the first section");

  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == ST_OUT))
    else $error("result presented without finishing the cascade");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    clr_mem |=> (lp_mem_r[0] == '0 && hp_mem_r[0] == '0))
    else $error("restart did not clear section state");

  a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_clipped) |->
      (out_filtered == {1'b0, {(rcbp_pkg::SAMPLE_W-1){1'b1}}}
       || out_filtered == {1'b1, {(rcbp_pkg::SAMPLE_W-1){1'b0}}}))
    else $error("clipped flag set on a value inside the range");

endmodule

`default_nettype wire
